@@ rtl/setq_pkg.sv @@
package setq_pkg;

  localparam int unsigned TIME_W   = 34;
  localparam int unsigned PERIOD_W = 20;
  localparam int unsigned DELAY_W  = 32;
  localparam int unsigned TAG_BITS = 4;

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_CHANGE = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_TICK   = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_DONE     = 3'd0,
    ST_FIRED    = 3'd1,
    ST_NONE     = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_FULL     = 3'd4
  } status_e;

  typedef struct packed {
    logic [1:0]          cmd;
    logic [TAG_BITS-1:0] event_tag;
    logic [DELAY_W-1:0]  delay;
  } in_item_t;

  typedef struct packed {
    logic [TAG_BITS-1:0] fired_tag;
    logic [2:0]          status;
    logic                last;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FIND,
    S_INSERT,
    S_TICK,
    S_REPLY
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture command, reset scan
    logic find_step; // advance tag search
    logic del_found; // delete found entry (shift later entries down)
    logic ins_step;  // advance insert search
    logic ins_do;    // insert at scan index
    logic tick_step; // process one entry of tick
    logic tick_end;  // commit kept count
  } ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic full;
    logic scan_end;   // scan index reached count
    logic tag_hit;    // current entry matches tag
    logic ins_hit;    // current entry time is later
    logic due;        // current tick entry fires
  } sts_t;

endpackage

@@ rtl/sorted_event_timer_queue.sv @@
// Sorted event timer queue.
// Input channel (in_valid_i/in_ready_o, in_item_i): one command per transaction:
//   add, change time, remove, tick. Output channel (out_valid_o/out_ready_i,
//   out_item_o): one result per command, or on a tick one per fired event
//   (a single none result if none fired), the final one marked by last.
// Config channel (cfg_valid_i/cfg_ready_o, cfg_data_i) writes update_period;
//   write only while idle. It is always ready.
// List scans take one entry per cycle; a tick scan holds while the receiver
//   stalls on an earlier fired result. A change deletes the entry, then scans
//   the list again to insert it at its new time. A tick visits each entry once.
// One command is in work at a time; the next is taken the cycle after the
//   final result of the current one is registered.
// Reset empties the list and sets the period to 1; list storage is not
//   cleared, only the entry count.
// A stalled receiver holds the result register; the block waits for it
//   before registering any further result.
module sorted_event_timer_queue #(
  parameter int unsigned SLOTS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  setq_pkg::in_item_t            in_item_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output setq_pkg::out_item_t           out_item_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [setq_pkg::PERIOD_W-1:0] cfg_data_i
);
  setq_pkg::ctl_t                ctl;
  setq_pkg::sts_t                sts;
  logic [setq_pkg::TAG_BITS-1:0] cur_tag;
  logic [setq_pkg::PERIOD_W-1:0] period_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= setq_pkg::PERIOD_W'(1);
    end else if (cfg_valid_i && cfg_ready_o) begin
      period_q <= cfg_data_i;
    end
  end

  setq_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o,
    .cmd_i(in_item_i.cmd), .out_valid_o, .out_ready_i,
    .out_o(out_item_o), .ctl_o(ctl), .sts_i(sts), .cur_tag_i(cur_tag)
  );

  setq_datapath #(.SLOTS(SLOTS)) u_dp (
    .clk_i, .rst_ni, .ctl_i(ctl), .sts_o(sts),
    .tag_i(in_item_i.event_tag), .delay_i(in_item_i.delay),
    .period_i(period_q), .cur_tag_o(cur_tag)
  );

endmodule

@@ rtl/setq_datapath.sv @@
module setq_datapath #(
  parameter int unsigned SLOTS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  setq_pkg::ctl_t                      ctl_i,
  output setq_pkg::sts_t                      sts_o,
  input  logic [setq_pkg::TAG_BITS-1:0]       tag_i,
  input  logic [setq_pkg::DELAY_W-1:0]        delay_i,
  input  logic [setq_pkg::PERIOD_W-1:0]       period_i,
  output logic [setq_pkg::TAG_BITS-1:0]       cur_tag_o
);
  localparam int unsigned IW = $clog2(SLOTS);
  localparam int unsigned CW = $clog2(SLOTS + 1);

  logic [setq_pkg::TAG_BITS-1:0] tag_q   [SLOTS];
  logic [setq_pkg::TIME_W-1:0]   time_q  [SLOTS];
  logic [CW-1:0]                 count_q;
  logic [CW-1:0]                 idx_q;
  logic [CW-1:0]                 kept_q;
  logic [setq_pkg::TAG_BITS-1:0] ctag_q;
  logic [setq_pkg::TIME_W-1:0]   ctime_q;
  logic [IW-1:0]                 idx;
  logic [IW-1:0]                 kidx;
  logic [setq_pkg::TIME_W-1:0]   per;

  assign idx  = idx_q[IW-1:0];
  assign kidx = kept_q[IW-1:0];
  assign per  = setq_pkg::TIME_W'(period_i);

  assign sts_o.full      = (count_q == CW'(SLOTS));
  assign sts_o.scan_end  = (idx_q >= count_q);
  assign sts_o.tag_hit   = (tag_q[idx] == ctag_q);
  assign sts_o.ins_hit   = (ctime_q < time_q[idx]);
  assign sts_o.due       = (time_q[idx] <= per);
  assign cur_tag_o       = tag_q[idx];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      idx_q   <= '0;
      kept_q  <= '0;
    end else begin
      if (ctl_i.load) begin
        idx_q  <= '0;
        kept_q <= '0;
      end
      if (ctl_i.find_step) begin
        idx_q <= idx_q + CW'(1);
      end
      if (ctl_i.del_found) begin
        count_q <= count_q - CW'(1);
        idx_q   <= '0;
      end
      if (ctl_i.ins_step) begin
        idx_q <= idx_q + CW'(1);
      end
      if (ctl_i.ins_do) begin
        count_q <= count_q + CW'(1);
      end
      if (ctl_i.tick_step) begin
        idx_q <= idx_q + CW'(1);
        if (!sts_o.due) begin
          kept_q <= kept_q + CW'(1);
        end
      end
      if (ctl_i.tick_end) begin
        count_q <= kept_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      ctag_q  <= tag_i;
      ctime_q <= setq_pkg::TIME_W'(delay_i) + per;
    end
    for (int i = 0; i < SLOTS; i++) begin
      if (ctl_i.del_found && (IW'(i) >= idx) && (i + 1 < SLOTS)) begin
        tag_q[i]  <= tag_q[(i + 1) % SLOTS];
        time_q[i] <= time_q[(i + 1) % SLOTS];
      end
      if (ctl_i.ins_do) begin
        if (IW'(i) == idx) begin
          tag_q[i]  <= ctag_q;
          time_q[i] <= ctime_q;
        end else if ((IW'(i) > idx) && (i > 0)) begin
          tag_q[i]  <= tag_q[(i + SLOTS - 1) % SLOTS];
          time_q[i] <= time_q[(i + SLOTS - 1) % SLOTS];
        end
      end
    end
    if (ctl_i.tick_step && !sts_o.due) begin
      tag_q[kidx]  <= tag_q[idx];
      time_q[kidx] <= time_q[idx] - per;
    end
  end

endmodule

@@ rtl/setq_ctrl.sv @@
module setq_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    cmd_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output setq_pkg::out_item_t           out_o,
  output setq_pkg::ctl_t                ctl_o,
  input  setq_pkg::sts_t                sts_i,
  input  logic [setq_pkg::TAG_BITS-1:0] cur_tag_i
);
  setq_pkg::state_e              state_q, state_d;
  setq_pkg::cmd_e                cmd_q;
  setq_pkg::status_e             stat_q, stat_d;
  setq_pkg::out_item_t           res_q, res_d;
  logic                          ovalid_q, ovalid_d;
  logic                          pend_q, pend_d;  // fired tag held until its last flag is known
  logic [setq_pkg::TAG_BITS-1:0] ptag_q, ptag_d;
  logic                          emit;
  logic                          free;

  assign free        = !ovalid_q || out_ready_i;
  assign in_ready_o  = (state_q == setq_pkg::S_IDLE);
  assign out_valid_o = ovalid_q;
  assign out_o       = res_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      setq_pkg::S_IDLE: begin
        if (in_valid_i) begin
          case (setq_pkg::cmd_e'(cmd_i))
            setq_pkg::CMD_ADD:  state_d = setq_pkg::S_INSERT;
            setq_pkg::CMD_TICK: state_d = setq_pkg::S_TICK;
            default:            state_d = setq_pkg::S_FIND;
          endcase
        end
      end
      setq_pkg::S_FIND: begin
        if (sts_i.scan_end) begin
          state_d = setq_pkg::S_REPLY;
        end else if (sts_i.tag_hit) begin
          state_d = (cmd_q == setq_pkg::CMD_CHANGE) ? setq_pkg::S_INSERT : setq_pkg::S_REPLY;
        end
      end
      setq_pkg::S_INSERT: begin
        if (sts_i.full || sts_i.scan_end || sts_i.ins_hit) begin
          state_d = setq_pkg::S_REPLY;
        end
      end
      setq_pkg::S_TICK: begin
        if (sts_i.scan_end && free) begin
          state_d = setq_pkg::S_IDLE;
        end
      end
      setq_pkg::S_REPLY: begin
        if (free) begin
          state_d = setq_pkg::S_IDLE;
        end
      end
      default: state_d = setq_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    ctl_o  = '0;
    emit   = 1'b0;
    res_d  = res_q;
    stat_d = stat_q;
    pend_d = pend_q;
    ptag_d = ptag_q;
    case (state_q)
      setq_pkg::S_IDLE: begin
        ctl_o.load = in_valid_i;
        stat_d     = setq_pkg::ST_DONE;
        pend_d     = 1'b0;
      end
      setq_pkg::S_FIND: begin
        if (sts_i.scan_end) begin
          stat_d = setq_pkg::ST_NOTFOUND;
        end else if (sts_i.tag_hit) begin
          ctl_o.del_found = 1'b1;
        end else begin
          ctl_o.find_step = 1'b1;
        end
      end
      setq_pkg::S_INSERT: begin
        if (sts_i.full) begin
          stat_d = setq_pkg::ST_FULL;
        end else if (sts_i.scan_end || sts_i.ins_hit) begin
          ctl_o.ins_do = 1'b1;
        end else begin
          ctl_o.ins_step = 1'b1;
        end
      end
      setq_pkg::S_TICK: begin
        if (sts_i.scan_end) begin
          // held tag is the final one; with none held, nothing fired
          if (free) begin
            ctl_o.tick_end = 1'b1;
            emit           = 1'b1;
            pend_d         = 1'b0;
            if (pend_q) begin
              res_d = '{fired_tag: ptag_q, status: setq_pkg::ST_FIRED, last: 1'b1};
            end else begin
              res_d = '{fired_tag: '0, status: setq_pkg::ST_NONE, last: 1'b1};
            end
          end
        end else if (!sts_i.due) begin
          ctl_o.tick_step = 1'b1;
        end else if (!pend_q) begin
          ctl_o.tick_step = 1'b1;
          pend_d          = 1'b1;
          ptag_d          = cur_tag_i;
        end else if (free) begin
          // another due entry: the held one is not final
          ctl_o.tick_step = 1'b1;
          emit            = 1'b1;
          res_d           = '{fired_tag: ptag_q, status: setq_pkg::ST_FIRED, last: 1'b0};
          ptag_d          = cur_tag_i;
        end
      end
      setq_pkg::S_REPLY: begin
        if (free) begin
          emit  = 1'b1;
          res_d = '{fired_tag: '0, status: stat_q, last: 1'b1};
        end
      end
      default: ;
    endcase
  end

  assign ovalid_d = emit || (ovalid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= setq_pkg::S_IDLE;
      ovalid_q <= 1'b0;
      pend_q   <= 1'b0;
      stat_q   <= setq_pkg::ST_DONE;
      cmd_q    <= setq_pkg::CMD_ADD;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
      pend_q   <= pend_d;
      stat_q   <= stat_d;
      if (in_valid_i && in_ready_o) begin
        cmd_q <= setq_pkg::cmd_e'(cmd_i);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q  <= res_d;
    ptag_q <= ptag_d;
  end

endmodule
